// ----- src/sba_pkg.sv -----
// Shared types and constants for the size-class bump allocator.
// No dependencies; every other file but sba_ram imports this package.
package sba_pkg;

	localparam int ADDR_W     = 20;
	localparam int SIZE_W     = 13;
	localparam int STATUS_W   = 2;
	localparam int ROUND_ADD  = 7;
	localparam int UNIT_SHIFT = 3;
	localparam int ROUND_W    = SIZE_W + 1;
	localparam int UNITS_W    = ROUND_W - UNIT_SHIFT;
	localparam int SUM_W      = 18;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_PAGE    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd3;

	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_IGNORE = 2'd0;
	localparam cmd_t CMD_BAD    = 2'd1;
	localparam cmd_t CMD_FREE   = 2'd2;
	localparam cmd_t CMD_ALLOC  = 2'd3;

	typedef struct packed {
		cmd_t cmd;
		logic never_fit;
	} ctrl_t;

endpackage

// ----- src/size_class_bump_allocator_core.sv -----
// Size-class allocator top level. An accepted item passes the front-end queue, the back-end
// S_CNT state (and S_POP when the block comes off a class free stack) and the output register.
// The back end takes no new item until the count-memory read and write-back of the last one
// (and its stack pop) are done and the output register is free or being popped.
// Reset: asynchronous; afterwards full stays high while the
// per-class counters are cleared. Depends on sba_pkg, sba_front, sba_back, sba_ram.
module size_class_bump_allocator_core import sba_pkg::*; #(
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_ENTRIES = 256,
	parameter int NUM_CLASSES = 64,
	parameter int STACK_DEPTH = 64,
	parameter int NUM_PAGES = 256,
	parameter int FIRST_OFFSET = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                operation,
	input  logic [SIZE_W-1:0]   request_size,
	input  logic [ADDR_W-1:0]   block_address,
	output logic                empty,
	input  logic                pop,
	output logic [ADDR_W-1:0]   granted_address,
	output logic [STATUS_W-1:0] status
);

	localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int SA_W = (NUM_CLASSES * STACK_DEPTH > 1) ?
		$clog2(NUM_CLASSES * STACK_DEPTH) : 1;

	logic               clearing;
	logic               q_valid;
	logic               q_take;
	ctrl_t              q_ctrl;
	logic [CLS_W-1:0]   q_cls;
	logic [SA_W-1:0]    q_base;
	logic [ROUND_W-1:0] q_rounded;
	logic [ADDR_W-1:0]  q_addr;

	sba_front #(
		.NUM_CLASSES (NUM_CLASSES),
		.STACK_DEPTH (STACK_DEPTH),
		.PAGE_BYTES  (PAGE_BYTES),
		.FIRST_OFFSET(FIRST_OFFSET)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.request_size (request_size),
		.block_address(block_address),
		.clearing     (clearing),
		.q_valid      (q_valid),
		.q_take       (q_take),
		.q_ctrl       (q_ctrl),
		.q_cls        (q_cls),
		.q_base       (q_base),
		.q_rounded    (q_rounded),
		.q_addr       (q_addr)
	);

	sba_back #(
		.PAGE_BYTES  (PAGE_BYTES),
		.MAX_ENTRIES (MAX_ENTRIES),
		.NUM_CLASSES (NUM_CLASSES),
		.STACK_DEPTH (STACK_DEPTH),
		.NUM_PAGES   (NUM_PAGES),
		.FIRST_OFFSET(FIRST_OFFSET)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.clearing       (clearing),
		.q_valid        (q_valid),
		.q_take         (q_take),
		.q_ctrl         (q_ctrl),
		.q_cls          (q_cls),
		.q_base         (q_base),
		.q_rounded      (q_rounded),
		.q_addr         (q_addr),
		.empty          (empty),
		.pop            (pop),
		.granted_address(granted_address),
		.status         (status)
	);

endmodule

// ----- src/sba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/sba_front.sv -----
// Front end: accepts requests, rounds the size, classifies the item and
// holds it in a two-entry queue for the back end. Depends on sba_pkg.
module sba_front import sba_pkg::*; #(
	parameter int NUM_CLASSES = 64,
	parameter int STACK_DEPTH = 64,
	parameter int PAGE_BYTES = 4096,
	parameter int FIRST_OFFSET = 16,
	localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
	localparam int SA_W = (NUM_CLASSES * STACK_DEPTH > 1) ?
		$clog2(NUM_CLASSES * STACK_DEPTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               operation,
	input  logic [SIZE_W-1:0]  request_size,
	input  logic [ADDR_W-1:0]  block_address,
	input  logic               clearing,
	output logic               q_valid,
	input  logic               q_take,
	output ctrl_t              q_ctrl,
	output logic [CLS_W-1:0]   q_cls,
	output logic [SA_W-1:0]    q_base,
	output logic [ROUND_W-1:0] q_rounded,
	output logic [ADDR_W-1:0]  q_addr
);

	logic [ROUND_W-1:0] size_sum;
	logic [UNITS_W-1:0] units;
	logic [UNITS_W-1:0] cls_full;
	logic [ROUND_W-1:0] rounded;
	logic [CLS_W-1:0]   cls;
	logic [SA_W-1:0]    base;
	logic               size_zero;
	logic               bad_cls;
	ctrl_t              ctrl;
	logic               accept;

	ctrl_t              ctrl_q    [2];
	logic [CLS_W-1:0]   cls_q     [2];
	logic [SA_W-1:0]    base_q    [2];
	logic [ROUND_W-1:0] rounded_q [2];
	logic [ADDR_W-1:0]  addr_q    [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;

	assign size_sum  = {1'b0, request_size} + ROUND_W'(ROUND_ADD);
	assign units     = size_sum[ROUND_W-1:UNIT_SHIFT];
	assign rounded   = {units, {UNIT_SHIFT{1'b0}}};
	assign cls_full  = units - UNITS_W'(1);
	assign cls       = CLS_W'(cls_full);
	assign size_zero = (request_size == '0);
	assign bad_cls   = (32'(units) > NUM_CLASSES);
	assign base      = SA_W'(32'(cls) * STACK_DEPTH);

	always_comb begin
		ctrl.never_fit = (32'(FIRST_OFFSET) + 32'(rounded) >= 32'(PAGE_BYTES));
		if (operation == OP_FREE) begin
			if (size_zero || block_address == '0) begin
				ctrl.cmd = CMD_IGNORE;
			end else if (bad_cls) begin
				ctrl.cmd = CMD_BAD;
			end else begin
				ctrl.cmd = CMD_FREE;
			end
		end else begin
			if (size_zero || bad_cls) begin
				ctrl.cmd = CMD_BAD;
			end else begin
				ctrl.cmd = CMD_ALLOC;
			end
		end
	end

	// hold off new items while the class counters are being cleared
	assign full   = (count_q == 2'd2) || clearing;
	assign accept = push && !full;

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_q[wr_ptr_q]    <= ctrl;
			cls_q[wr_ptr_q]     <= cls;
			base_q[wr_ptr_q]    <= base;
			rounded_q[wr_ptr_q] <= rounded;
			addr_q[wr_ptr_q]    <= block_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({accept, q_take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign q_valid   = (count_q != 2'd0);
	assign q_ctrl    = ctrl_q[rd_ptr_q];
	assign q_cls     = cls_q[rd_ptr_q];
	assign q_base    = base_q[rd_ptr_q];
	assign q_rounded = rounded_q[rd_ptr_q];
	assign q_addr    = addr_q[rd_ptr_q];

endmodule

// ----- src/sba_back.sv -----
// Back end: runs one queued item at a time against the class counters,
// the free stack memory and the bump pointer. Depends on sba_pkg, sba_ram.
module sba_back import sba_pkg::*; #(
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_ENTRIES = 256,
	parameter int NUM_CLASSES = 64,
	parameter int STACK_DEPTH = 64,
	parameter int NUM_PAGES = 256,
	parameter int FIRST_OFFSET = 16,
	localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
	localparam int SA_W = (NUM_CLASSES * STACK_DEPTH > 1) ?
		$clog2(NUM_CLASSES * STACK_DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	output logic                clearing,
	input  logic                q_valid,
	output logic                q_take,
	input  ctrl_t               q_ctrl,
	input  logic [CLS_W-1:0]    q_cls,
	input  logic [SA_W-1:0]     q_base,
	input  logic [ROUND_W-1:0]  q_rounded,
	input  logic [ADDR_W-1:0]   q_addr,
	output logic                empty,
	input  logic                pop,
	output logic [ADDR_W-1:0]   granted_address,
	output logic [STATUS_W-1:0] status
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int ENT_W = $clog2(MAX_ENTRIES + 1);
	localparam int PG_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int OFF_MAX = (PAGE_BYTES > FIRST_OFFSET) ? PAGE_BYTES : FIRST_OFFSET;
	localparam int OFF_W = $clog2(OFF_MAX + 1);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_CNT   = 2'd2;
	localparam logic [1:0] S_POP   = 2'd3;

	logic [1:0]          state_q;
	logic [CLS_W-1:0]    sweep_q;

	ctrl_t               ctrl_q;
	logic [CLS_W-1:0]    cls_q;
	logic [SA_W-1:0]     base_q;
	logic [ROUND_W-1:0]  rounded_q;
	logic [ADDR_W-1:0]   addr_q;

	logic [PG_W-1:0]     page_idx_q;
	logic [ADDR_W-1:0]   page_base_q;
	logic [OFF_W-1:0]    bump_off_q;
	logic [ENT_W-1:0]    entry_cnt_q;

	logic                out_valid_q;
	logic [ADDR_W-1:0]   granted_q;
	logic [STATUS_W-1:0] status_q;

	logic                cnt_we;
	logic [CLS_W-1:0]    cnt_waddr;
	logic [CNT_W-1:0]    cnt_wdata;
	logic [CNT_W-1:0]    cnt_rd;
	logic                st_we;
	logic [SA_W-1:0]     st_waddr;
	logic [SA_W-1:0]     st_raddr;
	logic [ADDR_W-1:0]   st_rd;

	logic                need_new;
	logic                last_page;
	logic [ADDR_W-1:0]   eff_base;
	logic [OFF_W-1:0]    eff_off;
	logic [ENT_W-1:0]    eff_ent;
	logic [ADDR_W-1:0]   bump_addr;

	logic                finish;
	logic                go_pop;
	logic                bump;
	logic [ADDR_W-1:0]   res_addr;
	logic [STATUS_W-1:0] res_status;

	sba_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_CLASSES)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(q_cls),
		.rdata(cnt_rd)
	);

	sba_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(NUM_CLASSES * STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(addr_q),
		.raddr(st_raddr),
		.rdata(st_rd)
	);

	assign clearing = (state_q == S_CLEAR);
	assign q_take   = (state_q == S_IDLE) && q_valid && (!out_valid_q || pop);

	// bump pointer: roll to the next page when the block would reach the page end or the entry limit is reached
	assign need_new = (SUM_W'(bump_off_q) + SUM_W'(rounded_q) >= SUM_W'(PAGE_BYTES)) ||
		(entry_cnt_q >= ENT_W'(MAX_ENTRIES));
	assign last_page = ({1'b0, page_idx_q} + (PG_W + 1)'(1)) >= (PG_W + 1)'(NUM_PAGES);
	assign eff_base  = need_new ? page_base_q + ADDR_W'(PAGE_BYTES) : page_base_q;
	assign eff_off   = need_new ? OFF_W'(FIRST_OFFSET) : bump_off_q;
	assign eff_ent   = need_new ? '0 : entry_cnt_q;
	assign bump_addr = eff_base + ADDR_W'(eff_off);

	assign st_waddr = base_q + SA_W'(cnt_rd);
	assign st_raddr = base_q + SA_W'(cnt_rd) - SA_W'(1);

	always_comb begin
		cnt_we     = 1'b0;
		cnt_waddr  = cls_q;
		cnt_wdata  = '0;
		st_we      = 1'b0;
		finish     = 1'b0;
		go_pop     = 1'b0;
		bump       = 1'b0;
		res_addr   = '0;
		res_status = ST_OK;
		case (state_q)
			S_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = sweep_q;
			end
			S_CNT: begin
				case (ctrl_q.cmd)
					CMD_IGNORE: begin
						finish = 1'b1;
					end
					CMD_BAD: begin
						finish     = 1'b1;
						res_status = ST_BAD_SIZE;
					end
					CMD_FREE: begin
						finish = 1'b1;
						if (cnt_rd >= CNT_W'(STACK_DEPTH)) begin
							res_status = ST_STACK_FULL;
						end else begin
							st_we     = 1'b1;
							cnt_we    = 1'b1;
							cnt_wdata = cnt_rd + CNT_W'(1);
						end
					end
					CMD_ALLOC: begin
						if (cnt_rd != '0) begin
							// pop the class stack; data arrives next cycle
							go_pop    = 1'b1;
							cnt_we    = 1'b1;
							cnt_wdata = cnt_rd - CNT_W'(1);
						end else begin
							finish = 1'b1;
							if (ctrl_q.never_fit) begin
								res_status = ST_BAD_SIZE;
							end else if (need_new && last_page) begin
								res_status = ST_NO_PAGE;
							end else begin
								bump     = 1'b1;
								res_addr = bump_addr;
							end
						end
					end
					default: begin
						finish = 1'b1;
					end
				endcase
			end
			S_POP: begin
				finish   = 1'b1;
				res_addr = st_rd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			ctrl_q    <= q_ctrl;
			cls_q     <= q_cls;
			base_q    <= q_base;
			rounded_q <= q_rounded;
			addr_q    <= q_addr;
		end
		if (finish) begin
			granted_q <= res_addr;
			status_q  <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			sweep_q     <= '0;
			page_idx_q  <= '0;
			page_base_q <= '0;
			bump_off_q  <= OFF_W'(FIRST_OFFSET);
			entry_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					sweep_q <= sweep_q + CLS_W'(1);
					if (sweep_q == CLS_W'(NUM_CLASSES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_take) begin
						state_q <= S_CNT;
					end
				end
				S_CNT: begin
					state_q <= go_pop ? S_POP : S_IDLE;
				end
				S_POP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (bump) begin
				if (need_new) begin
					page_idx_q <= page_idx_q + PG_W'(1);
				end
				page_base_q <= eff_base;
				bump_off_q  <= OFF_W'(SUM_W'(eff_off) + SUM_W'(rounded_q));
				entry_cnt_q <= eff_ent + ENT_W'(1);
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty           = !out_valid_q;
	assign granted_address = granted_q;
	assign status          = status_q;

endmodule

// ----- src/sba_checker.sv -----
// Port-level checks for the size-class allocator, bound to the top level.
// Depends on sba_pkg and size_class_bump_allocator_core.
module sba_checker import sba_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                full,
	input logic                empty,
	input logic                pop,
	input logic [ADDR_W-1:0]   granted_address,
	input logic [STATUS_W-1:0] status
);

	// a waiting result stays until it is taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result withdrawn before pop");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(granted_address) && $stable(status))
		else $error("waiting result changed");

	// a failed request never grants an address
	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != ST_OK |-> granted_address == '0)
		else $error("address granted with error status");

	// counter clearing blocks input right after reset
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> full)
		else $error("input open during counter clear");

endmodule

bind size_class_bump_allocator_core sba_checker u_sba_checker (.*);
